>>> rtl/core/i2cbs_pkg.sv
// shared types and constants for the i2c master bit sequencer
// command kinds, the queued command entry and the per-interval result
// no dependencies
package i2cbs_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int PHASE_W = 6;

  typedef enum logic [2:0] {
    KIND_START  = 3'd0,
    KIND_RSTART = 3'd1,
    KIND_WRITE  = 3'd2,
    KIND_READ   = 3'd3,
    KIND_STOP   = 3'd4
  } kind_t;

  // command as it waits between front and back
  typedef struct packed {
    kind_t                    kind;
    logic [BITS_PER_BYTE-1:0] tx_byte;
    logic                     nack_last;
    logic [BITS_PER_BYTE-1:0] rx_bits;
    logic                     ack_level;
    logic                     start_scl;
  } cmd_t;

  // one quarter-bit interval
  typedef struct packed {
    logic                     scl_level;
    logic                     sda_level;
    logic                     sda_drive;
    logic [BITS_PER_BYTE-1:0] byte_read;
    logic                     ack_seen;
    logic                     last_phase;
  } res_t;

endpackage

>>> rtl/core/i2cbs_fifo.sv
// small command queue between the front and the back of the sequencer
// register array with one write and one read port
// depends on nothing but its parameters
module i2cbs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/i2cbs_front.sv
// command front end: accepts commands, drops unknown kinds and tracks the
// scl level the previous command leaves behind
// depends on i2cbs_pkg
module i2cbs_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         kind,
  input  logic [i2cbs_pkg::BITS_PER_BYTE-1:0] tx_byte,
  input  logic                               nack_last,
  input  logic [i2cbs_pkg::BITS_PER_BYTE-1:0] rx_bits,
  input  logic                               ack_level,
  output logic                               push_valid,
  input  logic                               push_ready,
  output i2cbs_pkg::cmd_t                    push_cmd
);

  i2cbs_pkg::kind_t kind_in;
  logic             known;
  logic             end_scl;
  logic             clock_line;

  assign kind_in  = i2cbs_pkg::kind_t'(kind);
  assign in_ready = push_ready;

  always_comb begin
    known   = kind_in inside {i2cbs_pkg::KIND_START, i2cbs_pkg::KIND_RSTART,
                              i2cbs_pkg::KIND_WRITE, i2cbs_pkg::KIND_READ,
                              i2cbs_pkg::KIND_STOP};
    // read and stop finish with scl high, the others with scl low
    end_scl = kind_in inside {i2cbs_pkg::KIND_READ, i2cbs_pkg::KIND_STOP};
  end

  assign push_valid         = in_valid && known;
  assign push_cmd.kind      = kind_in;
  assign push_cmd.tx_byte   = tx_byte;
  assign push_cmd.nack_last = nack_last;
  assign push_cmd.rx_bits   = rx_bits;
  assign push_cmd.ack_level = ack_level;
  assign push_cmd.start_scl = clock_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_line <= 1'b1;
    end else if (in_valid && in_ready && known) begin
      clock_line <= end_scl;
    end
  end

endmodule

>>> rtl/core/i2cbs_back.sv
// command back end: steps each command through its quarter-bit intervals
// and holds the current interval in an output register
// depends on i2cbs_pkg
module i2cbs_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  i2cbs_pkg::cmd_t cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output i2cbs_pkg::res_t out_res
);

  localparam int PW = i2cbs_pkg::PHASE_W;

  i2cbs_pkg::cmd_t cmd_q;
  logic [PW-1:0]   phase;
  logic [PW-1:0]   phase_last;
  logic            busy;
  logic            adv;
  logic            at_last;
  i2cbs_pkg::res_t res_next;

  always_comb begin
    case (cmd_q.kind)
      i2cbs_pkg::KIND_START:  phase_last = PW'(1);
      i2cbs_pkg::KIND_RSTART: phase_last = PW'(4);
      i2cbs_pkg::KIND_WRITE:  phase_last = PW'(37);
      i2cbs_pkg::KIND_READ:   phase_last = PW'(35);
      i2cbs_pkg::KIND_STOP:   phase_last = PW'(4);
      default:                phase_last = '0;
    endcase
  end

  assign adv       = !out_valid || out_ready;
  assign at_last   = busy && (phase == phase_last);
  assign cmd_ready = adv && (!busy || at_last);

  // interval decode
  always_comb begin
    res_next            = '0;
    res_next.sda_drive  = 1'b1;
    res_next.last_phase = (phase == phase_last);
    case (cmd_q.kind)
      i2cbs_pkg::KIND_START: begin
        res_next.scl_level = (phase == '0) ? cmd_q.start_scl : 1'b0;
      end
      i2cbs_pkg::KIND_RSTART: begin
        res_next.scl_level = (phase == PW'(2)) || (phase == PW'(3));
        res_next.sda_level = (phase < PW'(3));
      end
      i2cbs_pkg::KIND_WRITE: begin
        res_next.scl_level = phase[1];
        if (phase < PW'(32)) begin
          // msb first: bit index counts down as the bit number counts up
          res_next.sda_level = cmd_q.tx_byte[~phase[4:2]];
        end else if (phase < PW'(36)) begin
          res_next.sda_level = 1'b1;
          res_next.sda_drive = 1'b0;
        end else begin
          res_next.sda_level = 1'b1;
        end
        if (phase == phase_last) begin
          res_next.ack_seen = !cmd_q.ack_level;
        end
      end
      i2cbs_pkg::KIND_READ: begin
        res_next.scl_level = phase[1];
        if (phase < PW'(32)) begin
          res_next.sda_level = 1'b1;
          res_next.sda_drive = 1'b0;
        end else begin
          res_next.sda_level = cmd_q.nack_last;
        end
        if (phase == phase_last) begin
          res_next.byte_read = cmd_q.rx_bits;
        end
      end
      i2cbs_pkg::KIND_STOP: begin
        res_next.scl_level = (phase >= PW'(2));
        res_next.sda_level = (phase >= PW'(3));
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= busy;
      if (busy) begin
        out_res <= res_next;
      end
      if (cmd_ready && cmd_valid) begin
        busy  <= 1'b1;
        cmd_q <= cmd;
        phase <= '0;
      end else begin
        if (busy) begin
          phase <= phase + PW'(1);
        end
        if (at_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (phase <= phase_last))
    else $error("interval counter past last interval");

  a_busy_emits: assert property (@(posedge clk) disable iff (rst)
    (busy && adv) |=> out_valid)
    else $error("active command produced no interval");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (at_last && adv && !cmd_valid) |=> !busy)
    else $error("sequencer stayed busy after last interval");
`endif

endmodule

>>> rtl/core/i2c_master_bit_sequencer.sv
// i2c master bit sequencer, top level
// front end, command queue and interval back end
// depends on i2cbs_pkg, i2cbs_front, i2cbs_fifo, i2cbs_back
//
// usage:
//   s_axis carries one bus command per transaction: tuser holds the kind
//   (start, repeated start, write byte, read byte, stop); tdata holds the
//   byte to send, the nack flag and the slave's sampled levels.
//   m_axis carries one transaction per quarter-bit interval with the scl
//   level, sda level and sda drive enable; tlast marks the final interval
//   of a command, which also carries the byte read or the ack seen.
//   a command gives 2 (start), 5 (repeated start, stop), 36 (read) or
//   38 (write) intervals, one per cycle while m_axis_tready is high; the
//   interval counter of the back end sets these counts.
//   a taken command passes through the queue and the back end's command
//   register before its first interval is registered onto m_axis.
//   unknown kinds are taken and dropped with no output.
//   the queue keeps taking commands while the back end works; when the
//   receiver stalls, the held interval waits and the queue fills up.
//   reset empties the queue and sets the front end's tracked scl level high.
module i2c_master_bit_sequencer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tx_byte[7:0], nack_last[8], rx_bits[16:9], ack_level[17], zero [23:18]
  input  logic [23:0] s_axis_tdata,
  // kind[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_level[0], sda_level[1], sda_drive[2], byte_read[10:3],
  // ack_seen[11], zero [15:12]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  // command handoff from front to queue
  logic            push_valid;
  logic            push_ready;
  i2cbs_pkg::cmd_t push_cmd;

  // queue to back end
  logic                               pop_valid;
  logic                               pop_ready;
  logic [$bits(i2cbs_pkg::cmd_t)-1:0] pop_bits;
  i2cbs_pkg::res_t                    res;

  i2cbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .kind       (s_axis_tuser),
    .tx_byte    (s_axis_tdata[7:0]),
    .nack_last  (s_axis_tdata[8]),
    .rx_bits    (s_axis_tdata[16:9]),
    .ack_level  (s_axis_tdata[17]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  i2cbs_fifo #(
    .WIDTH ($bits(i2cbs_pkg::cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_bits)
  );

  i2cbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (i2cbs_pkg::cmd_t'(pop_bits)),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  // pack the interval onto the master stream
  assign m_axis_tdata = {4'b0000, res.ack_seen, res.byte_read,
                         res.sda_drive, res.sda_level, res.scl_level};
  assign m_axis_tlast = res.last_phase;

endmodule
